>>> design/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, constants and arithmetic step functions for the triangle
// plane setup pipeline.
// ----------------------------------------------------------------------------
package tps_pkg;

	localparam int CRD_W    = 24;   // Q15.8 vertex coordinate
	localparam int NRM_W    = 16;   // Q1.14 normal component
	localparam int DIST_W   = 25;   // Q16.8 plane distance
	localparam int Q_FRAC   = 14;   // fraction bits of the normal

	// pipeline layout, stages numbered from 1
	localparam int NSTG     = 32;
	localparam int SQ_STG   = 16;   // square root: two result bits per stage
	localparam int SQ_BASE  = 7;
	localparam int DIV_STG  = 5;    // divider: three quotient bits per stage
	localparam int DIV_BASE = 24;
	localparam int QUO_W    = 15;

	localparam logic signed [DIST_W-1:0] DIST_MAX = 25'sd16777215;
	localparam logic signed [DIST_W-1:0] DIST_MIN = -25'sd16777216;

	// register indexes (word address bit 2)
	localparam logic REG_SWAP_YZ  = 1'b0;
	localparam logic REG_REV_WIND = 1'b1;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef logic signed [CRD_W-1:0] crd_t;
	// [vertex][axis]
	typedef logic [2:0][2:0][CRD_W-1:0] tri_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic [31:0] rem;
		logic        qb;
	} dv_t;

	// one digit of a restoring square root
	function automatic sq_t sq_step(input logic [33:0] rem, input logic [31:0] root,
			input logic [1:0] b);
		logic [35:0] r2;
		logic [35:0] t;
		logic [35:0] d;
		sq_t res;
		r2 = {rem, b};
		t  = {2'b00, root, 2'b01};
		d  = r2 - t;
		if (r2 >= t) begin
			res.rem  = d[33:0];
			res.root = {root[30:0], 1'b1};
		end else begin
			res.rem  = r2[33:0];
			res.root = {root[30:0], 1'b0};
		end
		return res;
	endfunction

	// one bit of a restoring division, remainder kept below the divisor
	function automatic dv_t dv_step(input logic [31:0] rem, input logic nb,
			input logic [31:0] den);
		logic [32:0] r2;
		logic [32:0] d;
		dv_t res;
		r2 = {rem, nb};
		d  = r2 - {1'b0, den};
		if (r2 >= {1'b0, den}) begin
			res.rem = d[31:0];
			res.qb  = 1'b1;
		end else begin
			res.rem = r2[31:0];
			res.qb  = 1'b0;
		end
		return res;
	endfunction

endpackage

>>> design/tps_isqrt.sv
// ----------------------------------------------------------------------------
// tps_isqrt
// Pipelined integer square root, floor(sqrt) of a 64-bit radicand, two
// result bits per stage.
// ----------------------------------------------------------------------------
module tps_isqrt import tps_pkg::*; (
	input  logic              clk,
	input  logic [SQ_STG-1:0] ld,
	input  logic [63:0]       rad,
	output logic [31:0]       root
);

	sq_t         st_s  [0:SQ_STG-1];
	logic [63:0] rad_s [0:SQ_STG-2];

	for (genvar j = 0; j < SQ_STG; j++) begin : g_stg
		sq_t         prev;
		sq_t         a;
		sq_t         b;
		logic [63:0] prad;

		if (j == 0) begin : g_first
			assign prev = '0;
			assign prad = rad;
		end else begin : g_next
			assign prev = st_s[j-1];
			assign prad = rad_s[j-1];
		end

		always_comb begin
			a = sq_step(prev.rem, prev.root, prad[2*(31-2*j) +: 2]);
			b = sq_step(a.rem, a.root, prad[2*(30-2*j) +: 2]);
		end

		always_ff @(posedge clk) begin
			if (ld[j]) begin
				st_s[j] <= b;
			end
		end

		if (j < SQ_STG-1) begin : g_carry
			always_ff @(posedge clk) begin
				if (ld[j]) begin
					rad_s[j] <= prad;
				end
			end
		end
	end

	assign root = st_s[SQ_STG-1].root;

endmodule

>>> design/tps_div.sv
// ----------------------------------------------------------------------------
// tps_div
// Three-lane pipelined restoring divider, 15-bit quotients, three bits per
// stage, one shared divisor.
// ----------------------------------------------------------------------------
module tps_div import tps_pkg::*; (
	input  logic                   clk,
	input  logic [DIV_STG-1:0]     ld,
	input  logic [2:0][45:0]       num,
	input  logic [31:0]            den,
	output logic [2:0][QUO_W-1:0]  quot
);

	logic [2:0][31:0]      rem_s [0:DIV_STG-1];
	logic [2:0][QUO_W-1:0] q_s   [0:DIV_STG-1];
	logic [2:0][QUO_W-1:0] num_s [0:DIV_STG-2];
	logic [31:0]           den_s [0:DIV_STG-2];

	for (genvar j = 0; j < DIV_STG; j++) begin : g_stg
		logic [2:0][31:0]      prem;
		logic [2:0][QUO_W-1:0] pq;
		logic [2:0][QUO_W-1:0] pnum;
		logic [31:0]           pden;
		logic [2:0][31:0]      nrem;
		logic [2:0][QUO_W-1:0] nq;

		if (j == 0) begin : g_first
			always_comb begin
				for (int k = 0; k < 3; k++) begin
					prem[k] = {1'b0, num[k][45:QUO_W]};
					pnum[k] = num[k][QUO_W-1:0];
				end
				pq   = '0;
				pden = den;
			end
		end else begin : g_next
			assign prem = rem_s[j-1];
			assign pq   = q_s[j-1];
			assign pnum = num_s[j-1];
			assign pden = den_s[j-1];
		end

		always_comb begin
			dv_t              d;
			logic [31:0]      r;
			logic [QUO_W-1:0] q;
			for (int k = 0; k < 3; k++) begin
				r = prem[k];
				q = pq[k];
				for (int t = 0; t < 3; t++) begin
					d = dv_step(r, pnum[k][QUO_W-1-3*j-t], pden);
					r = d.rem;
					q = {q[QUO_W-2:0], d.qb};
				end
				nrem[k] = r;
				nq[k]   = q;
			end
		end

		always_ff @(posedge clk) begin
			if (ld[j]) begin
				rem_s[j] <= nrem;
				q_s[j]   <= nq;
			end
		end

		if (j < DIV_STG-1) begin : g_carry
			always_ff @(posedge clk) begin
				if (ld[j]) begin
					num_s[j] <= pnum;
					den_s[j] <= pden;
				end
			end
		end
	end

	assign quot = q_s[DIV_STG-1];

endmodule

>>> design/triangle_plane_setup_core.sv
// Throughput: one triangle per cycle; each stage holds one transaction and
// stalls only when the stage after it is full and not moving.
// Reset: arst_n clears all stage valid bits and sets swap_y_and_z to 0 and
// reverse_winding to 1; datapath registers are not reset.
// ----------------------------------------------------------------------------
// triangle_plane_setup_core
// Triangle setup: unit face normal, plane distance, dominant axis and the
// vertices projected onto the two remaining axes.
// ----------------------------------------------------------------------------
module triangle_plane_setup_core import tps_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	// triangle channel
	input  logic                     tri_valid,
	output logic                     tri_ready,
	input  logic signed [CRD_W-1:0]  first_x,
	input  logic signed [CRD_W-1:0]  first_y,
	input  logic signed [CRD_W-1:0]  first_z,
	input  logic signed [CRD_W-1:0]  second_x,
	input  logic signed [CRD_W-1:0]  second_y,
	input  logic signed [CRD_W-1:0]  second_z,
	input  logic signed [CRD_W-1:0]  third_x,
	input  logic signed [CRD_W-1:0]  third_y,
	input  logic signed [CRD_W-1:0]  third_z,
	// result channel
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic signed [NRM_W-1:0]  normal_x,
	output logic signed [NRM_W-1:0]  normal_y,
	output logic signed [NRM_W-1:0]  normal_z,
	output logic signed [DIST_W-1:0] plane_distance,
	output logic [1:0]               dominant_axis,
	output logic signed [CRD_W-1:0]  proj0_u,
	output logic signed [CRD_W-1:0]  proj0_v,
	output logic signed [CRD_W-1:0]  proj1_u,
	output logic signed [CRD_W-1:0]  proj1_v,
	output logic signed [CRD_W-1:0]  proj2_u,
	output logic signed [CRD_W-1:0]  proj2_v,
	output logic                     degenerate
);

	// ---------------------------------------------------------------- config
	logic swap_q;
	logic rev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0;
			rev_q  <= 1'b1;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_SWAP_YZ:  swap_q <= pwdata[0];
				REG_REV_WIND: rev_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			REG_SWAP_YZ:  prdata = {31'd0, swap_q};
			REG_REV_WIND: prdata = {31'd0, rev_q};
			default:      prdata = '0;
		endcase
	end

	// ------------------------------------------------------ valid/ready chain
	// Each stage may load when it is empty or its contents move on, so
	// bubbles are squeezed out; res_ready ripples combinationally back to tri_ready.
	logic vld_q [1:NSTG];
	logic rdy   [1:NSTG];

	always_comb begin
		rdy[NSTG] = !vld_q[NSTG] || res_ready;
		for (int k = NSTG-1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= tri_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign tri_ready = rdy[1];
	assign res_valid = vld_q[NSTG];

	// ------------------------------------------------- stage 1: remap, edges
	// Optional Y/Z exchange per vertex and vertex 1/2 exchange for winding.
	crd_t              raw [0:2][0:2];
	tri_t              vin;
	logic signed [24:0] e1 [0:2];
	logic signed [24:0] e2 [0:2];

	assign raw[0][0] = first_x;
	assign raw[0][1] = first_y;
	assign raw[0][2] = first_z;
	assign raw[1][0] = second_x;
	assign raw[1][1] = second_y;
	assign raw[1][2] = second_z;
	assign raw[2][0] = third_x;
	assign raw[2][1] = third_y;
	assign raw[2][2] = third_z;

	always_comb begin
		logic [1:0] vk;
		logic [1:0] cj;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				vk = (rev_q && k != 0) ? 2'(3 - k) : 2'(k);
				cj = (swap_q && j != 0) ? 2'(3 - j) : 2'(j);
				vin[k][j] = raw[vk][cj];
			end
		end
		for (int j = 0; j < 3; j++) begin
			e1[j] = 25'($signed(vin[1][j])) - 25'($signed(vin[0][j]));
			e2[j] = 25'($signed(vin[2][j])) - 25'($signed(vin[0][j]));
		end
	end

	tri_t               vtx_s [1:NSTG-1];
	logic signed [24:0] e1_s1 [0:2];
	logic signed [24:0] e2_s1 [0:2];

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			vtx_s[1] <= vin;
			e1_s1    <= e1;
			e2_s1    <= e2;
		end
	end

	// vertex carry through the whole pipe
	for (genvar k = 2; k <= NSTG-1; k++) begin : g_vtx
		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				vtx_s[k] <= vtx_s[k-1];
			end
		end
	end

	// ---------------------------------------------- stage 2: cross products
	logic signed [49:0] p_s2 [0:5];

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
		end
	end

	// --------------------------------------- stage 3: cross, sign, magnitude
	logic signed [50:0] cr  [0:2];
	logic signed [50:0] cra [0:2];
	logic [2:0][49:0]   mag_s3;
	logic [2:0]         neg_s   [3:NSTG-3];
	logic               degen_s [3:NSTG-3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cr[k]  = 51'(p_s2[2*k]) - 51'(p_s2[2*k+1]);
			cra[k] = cr[k][50] ? -cr[k] : cr[k];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			for (int k = 0; k < 3; k++) begin
				mag_s3[k]    <= cra[k][49:0];
				neg_s[3][k]  <= cr[k][50];
			end
			degen_s[3] <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
		end
	end

	for (genvar k = 4; k <= NSTG-3; k++) begin : g_flags
		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				neg_s[k]   <= neg_s[k-1];
				degen_s[k] <= degen_s[k-1];
			end
		end
	end

	// ------------------------------------- stage 4: scale below 2^31
	logic [49:0]      mor;
	logic [4:0]       shamt;
	logic [49:0]      msh [0:2];
	logic [2:0][30:0] ms_s [4:DIV_BASE-2];

	always_comb begin
		mor   = mag_s3[0] | mag_s3[1] | mag_s3[2];
		shamt = '0;
		for (int i = 31; i < 50; i++) begin
			if (mor[i]) begin
				shamt = 5'(i - 30);
			end
		end
		for (int k = 0; k < 3; k++) begin
			msh[k] = mag_s3[k] >> shamt;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			for (int k = 0; k < 3; k++) begin
				ms_s[4][k] <= msh[k][30:0];
			end
		end
	end

	for (genvar k = 5; k <= DIV_BASE-2; k++) begin : g_ms
		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				ms_s[k] <= ms_s[k-1];
			end
		end
	end

	// --------------------------------------- stages 5-6: sum of squares
	logic [61:0] sqr_s5 [0:2];
	logic [63:0] sum_s6;

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			for (int k = 0; k < 3; k++) begin
				sqr_s5[k] <= 62'(ms_s[4][k]) * 62'(ms_s[4][k]);
			end
		end
		if (rdy[6]) begin
			sum_s6 <= 64'(sqr_s5[0]) + 64'(sqr_s5[1]) + 64'(sqr_s5[2]);
		end
	end

	// --------------------------------------- stages 7-22: vector length
	logic [SQ_STG-1:0] sq_ld;
	logic [31:0]       len_s22;

	always_comb begin
		for (int j = 0; j < SQ_STG; j++) begin
			sq_ld[j] = rdy[SQ_BASE + j];
		end
	end

	tps_isqrt u_isqrt (
		.clk  (clk),
		.ld   (sq_ld),
		.rad  (sum_s6),
		.root (len_s22)
	);

	// -------------------------------- stage 23: rounded numerators
	logic [2:0][45:0] num_s23;
	logic [31:0]      den_s23;

	always_ff @(posedge clk) begin
		if (rdy[DIV_BASE-1]) begin
			for (int k = 0; k < 3; k++) begin
				num_s23[k] <= 46'({ms_s[DIV_BASE-2][k], 14'd0}) + 46'(len_s22[31:1]);
			end
			den_s23 <= len_s22;
		end
	end

	// --------------------------------------- stages 24-28: normalise
	logic [DIV_STG-1:0]    dv_ld;
	logic [2:0][QUO_W-1:0] quot_s28;

	always_comb begin
		for (int j = 0; j < DIV_STG; j++) begin
			dv_ld[j] = rdy[DIV_BASE + j];
		end
	end

	tps_div u_div (
		.clk  (clk),
		.ld   (dv_ld),
		.num  (num_s23),
		.den  (den_s23),
		.quot (quot_s28)
	);

	// ---------------------------------------- stage 29: signed normal
	logic [2:0][NRM_W-1:0] nrm_s [29:31];

	always_ff @(posedge clk) begin
		if (rdy[29]) begin
			for (int k = 0; k < 3; k++) begin
				if (degen_s[28]) begin
					nrm_s[29][k] <= '0;
				end else if (neg_s[28][k]) begin
					nrm_s[29][k] <= -NRM_W'({1'b0, quot_s28[k]});
				end else begin
					nrm_s[29][k] <= NRM_W'({1'b0, quot_s28[k]});
				end
			end
		end
	end

	for (genvar k = 30; k <= 31; k++) begin : g_nrm
		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				nrm_s[k] <= nrm_s[k-1];
			end
		end
	end

	// ------------------------------- stages 30-31: normal dot vertex 0
	logic signed [39:0] dp_s30 [0:2];
	logic signed [41:0] acc_s31;

	always_ff @(posedge clk) begin
		if (rdy[30]) begin
			for (int k = 0; k < 3; k++) begin
				dp_s30[k] <= $signed(nrm_s[29][k]) * $signed(vtx_s[29][0][k]);
			end
		end
		if (rdy[31]) begin
			acc_s31 <= 42'(dp_s30[0]) + 42'(dp_s30[1]) + 42'(dp_s30[2]);
		end
	end

	// degenerate flag is taken from stage 29 and carried alongside
	logic degen_s30;
	logic degen_s31;

	always_ff @(posedge clk) begin
		if (rdy[30]) begin
			degen_s30 <= degen_s[NSTG-3];
		end
		if (rdy[31]) begin
			degen_s31 <= degen_s30;
		end
	end

	// ----------------------- stage 32: round, saturate, axis, projection
	logic signed [41:0]       rnd;
	logic signed [27:0]       dsh;
	logic signed [DIST_W-1:0] dsat;
	logic signed [NRM_W-1:0]  nx;
	logic signed [NRM_W-1:0]  ny;
	logic signed [NRM_W-1:0]  nz;
	logic [NRM_W-1:0]         ax;
	logic [NRM_W-1:0]         ay;
	logic [NRM_W-1:0]         az;
	axis_t                    axis;
	logic [1:0]               pu;
	logic [1:0]               pv;

	always_comb begin
		rnd = acc_s31 + 42'sd8192;
		dsh = 28'(rnd >>> Q_FRAC);
		if (dsh > 28'(DIST_MAX)) begin
			dsat = DIST_MAX;
		end else if (dsh < 28'(DIST_MIN)) begin
			dsat = DIST_MIN;
		end else begin
			dsat = dsh[DIST_W-1:0];
		end

		nx = $signed(nrm_s[31][0]);
		ny = $signed(nrm_s[31][1]);
		nz = $signed(nrm_s[31][2]);
		ax = nx[NRM_W-1] ? -nx : nx;
		ay = ny[NRM_W-1] ? -ny : ny;
		az = nz[NRM_W-1] ? -nz : nz;
		// strict wins for X; Y wins ties with X but not with Z
		if (ax > ay) begin
			axis = (ax > az) ? AXIS_X : AXIS_Z;
		end else begin
			axis = (ay > az) ? AXIS_Y : AXIS_Z;
		end

		case (axis)
			AXIS_X:  begin pu = 2'd1; pv = 2'd2; end
			AXIS_Y:  begin pu = 2'd0; pv = 2'd2; end
			default: begin pu = 2'd0; pv = 2'd1; end
		endcase
	end

	logic [2:0][NRM_W-1:0]       nrm_q;
	logic signed [DIST_W-1:0]    dist_q;
	axis_t                       axis_q;
	logic [2:0][1:0][CRD_W-1:0]  proj_q;
	logic                        degen_q;

	always_ff @(posedge clk) begin
		if (rdy[NSTG]) begin
			nrm_q   <= nrm_s[31];
			dist_q  <= dsat;
			axis_q  <= axis;
			degen_q <= degen_s31;
			for (int k = 0; k < 3; k++) begin
				proj_q[k][0] <= vtx_s[31][k][pu];
				proj_q[k][1] <= vtx_s[31][k][pv];
			end
		end
	end

	assign normal_x       = $signed(nrm_q[0]);
	assign normal_y       = $signed(nrm_q[1]);
	assign normal_z       = $signed(nrm_q[2]);
	assign plane_distance = dist_q;
	assign dominant_axis  = axis_q;
	assign proj0_u        = $signed(proj_q[0][0]);
	assign proj0_v        = $signed(proj_q[0][1]);
	assign proj1_u        = $signed(proj_q[1][0]);
	assign proj1_v        = $signed(proj_q[1][1]);
	assign proj2_u        = $signed(proj_q[2][0]);
	assign proj2_v        = $signed(proj_q[2][1]);
	assign degenerate     = degen_q;

endmodule

>>> design/tps_chk.sv
// ----------------------------------------------------------------------------
// tps_chk
// Port-level checks on the result channel of the triangle plane setup core.
// ----------------------------------------------------------------------------
module tps_chk import tps_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic signed [NRM_W-1:0]  normal_x,
	input logic signed [NRM_W-1:0]  normal_y,
	input logic signed [NRM_W-1:0]  normal_z,
	input logic signed [DIST_W-1:0] plane_distance,
	input logic [1:0]               dominant_axis,
	input logic                     degenerate
);

	// a degenerate triangle gives a zero normal, zero distance and axis Z
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0
			&& plane_distance == 0 && dominant_axis == AXIS_Z)
		else $error("degenerate result not zeroed");

	// a proper triangle has a non-zero normal component on its dominant axis
	a_dom_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !degenerate |->
			(dominant_axis == AXIS_X && normal_x != 0)
			|| (dominant_axis == AXIS_Y && normal_y != 0)
			|| (dominant_axis == AXIS_Z && normal_z != 0))
		else $error("dominant axis component is zero");

	// unit normal components stay within one in Q1.14
	a_nrm_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> normal_x >= -16'sd16384 && normal_x <= 16'sd16384
			&& normal_y >= -16'sd16384 && normal_y <= 16'sd16384
			&& normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
		else $error("normal component out of range");

	// a stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(normal_x)
			&& $stable(plane_distance) && $stable(dominant_axis))
		else $error("result changed while stalled");

endmodule

bind triangle_plane_setup_core tps_chk u_tps_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res_valid),
	.res_ready      (res_ready),
	.normal_x       (normal_x),
	.normal_y       (normal_y),
	.normal_z       (normal_z),
	.plane_distance (plane_distance),
	.dominant_axis  (dominant_axis),
	.degenerate     (degenerate)
);
